/* rtl/pbl_pkg.sv */
// shared constants, codes and beat types for the packet block-list filter
package pbl_pkg;

    localparam int ADDR_ENTRIES = 64;
    localparam int PORT_ENTRIES = 32;
    localparam int APP_TYPES    = 32;

    localparam int AIDX_W   = (ADDR_ENTRIES > 1) ? $clog2(ADDR_ENTRIES) : 1;
    localparam int PIDX_W   = (PORT_ENTRIES > 1) ? $clog2(PORT_ENTRIES) : 1;
    localparam int SCAN_LEN = (ADDR_ENTRIES > PORT_ENTRIES) ? ADDR_ENTRIES : PORT_ENTRIES;
    localparam int SCAN_W   = $clog2(SCAN_LEN + 1);

    localparam int CMD_W      = 3;
    localparam int IP_W       = 32;
    localparam int PORT_W     = 16;
    localparam int APP_W      = 5;
    localparam int REASON_W   = 2;
    localparam int IPCNT_W    = 7;
    localparam int APPCNT_W   = 6;
    localparam int PORTCNT_W  = 6;

    // two-entry queues between the parts
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_CHECK       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_BLOCK_IP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UNBLOCK_IP  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BLOCK_APP   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_UNBLOCK_APP = 3'd4;
    localparam logic [CMD_W-1:0] CMD_BLOCK_PORT  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNBLOCK_PORT= 3'd6;
    localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd7;

    localparam logic [REASON_W-1:0] RSN_NONE = 2'd0;
    localparam logic [REASON_W-1:0] RSN_ADDR = 2'd1;
    localparam logic [REASON_W-1:0] RSN_APP  = 2'd2;
    localparam logic [REASON_W-1:0] RSN_PORT = 2'd3;

    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic                 scan;
        logic [IP_W-1:0]      ip;
        logic [PORT_W-1:0]    port;
        logic [APP_TYPES-1:0] app_sel;
    } item_t;

    typedef struct packed {
        logic                 blocked;
        logic [REASON_W-1:0]  reason;
        logic                 status;
        logic [IPCNT_W-1:0]   ip_rules;
        logic [APPCNT_W-1:0]  app_rules;
        logic [PORTCNT_W-1:0] port_rules;
    } res_t;

endpackage

/* rtl/pbl_front.sv */
// front part: accepts input beats, classifies them and queues them for the back part
module pbl_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [pbl_pkg::CMD_W-1:0]   cmd,
    input  logic [pbl_pkg::IP_W-1:0]    ip_addr,
    input  logic [pbl_pkg::PORT_W-1:0]  port_num,
    input  logic [pbl_pkg::APP_W-1:0]   app_id,
    output logic                        q_valid,
    output pbl_pkg::item_t              q_item,
    input  logic                        q_take
);
    import pbl_pkg::*;

    item_t              dec;
    item_t              mem_q [Q_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    always_comb
    begin
        dec.cmd  = cmd;
        dec.ip   = ip_addr;
        dec.port = port_num;
        // one-hot application select, zero when the type is out of range
        for (int j = 0; j < APP_TYPES; j++)
        begin
            dec.app_sel[j] = (int'(app_id) == j);
        end
        unique case (cmd)
            CMD_CHECK, CMD_BLOCK_IP, CMD_UNBLOCK_IP,
            CMD_BLOCK_PORT, CMD_UNBLOCK_PORT:
                dec.scan = 1'b1;
            CMD_BLOCK_APP, CMD_UNBLOCK_APP, CMD_CLEAR:
                dec.scan = 1'b0;
        endcase
    end

    assign full    = (cnt_reg == QCNT_W'(Q_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = mem_q[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_q[wr_ptr_reg] <= dec;
        end
    end

endmodule

/* rtl/pbl_back.sv */
// back part: rule tables, one-entry-per-cycle table scan and command execution
module pbl_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  pbl_pkg::item_t  q_item,
    output logic            q_take,
    output logic            res_push,
    output pbl_pkg::res_t   res_item,
    input  logic            res_full
);
    import pbl_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [IP_W-1:0]    addr_mem [ADDR_ENTRIES];
    logic [PORT_W-1:0]  port_mem [PORT_ENTRIES];
    logic [IP_W-1:0]    addr_rd_reg;
    logic [PORT_W-1:0]  port_rd_reg;

    logic [1:0]              state_reg, state_next;
    item_t                   cur_reg, cur_next;
    logic [SCAN_W-1:0]       idx_reg, idx_next;
    logic                    rv_reg, rv_next;
    logic [SCAN_W-1:0]       ridx_reg;

    logic                    a_found_reg, a_found_next;
    logic [AIDX_W-1:0]       a_hit_reg, a_hit_next;
    logic                    a_free_reg, a_free_next;
    logic [AIDX_W-1:0]       a_fidx_reg, a_fidx_next;
    logic                    p_found_reg, p_found_next;
    logic [PIDX_W-1:0]       p_hit_reg, p_hit_next;
    logic                    p_free_reg, p_free_next;
    logic [PIDX_W-1:0]       p_fidx_reg, p_fidx_next;

    logic [ADDR_ENTRIES-1:0] addr_valid_reg, addr_valid_next;
    logic [PORT_ENTRIES-1:0] port_valid_reg, port_valid_next;
    logic [APP_TYPES-1:0]    app_mask_reg, app_mask_next;
    logic [IPCNT_W-1:0]      ip_cnt_reg, ip_cnt_next;
    logic [APPCNT_W-1:0]     app_cnt_reg, app_cnt_next;
    logic [PORTCNT_W-1:0]    port_cnt_reg, port_cnt_next;
    res_t                    res_reg, res_next;

    logic                    issue;
    logic                    a_in, a_vb, a_match;
    logic                    p_in, p_vb, p_match;
    logic                    app_hit;
    logic                    a_we, p_we;

    assign issue = (state_reg == S_SCAN) && (idx_reg < SCAN_W'(SCAN_LEN));

    // returned read beat: compare against the key, note first free slot
    assign a_in    = ridx_reg < SCAN_W'(ADDR_ENTRIES);
    assign a_vb    = addr_valid_reg[ridx_reg[AIDX_W-1:0]];
    assign a_match = a_in && a_vb && (addr_rd_reg == cur_reg.ip);
    assign p_in    = ridx_reg < SCAN_W'(PORT_ENTRIES);
    assign p_vb    = port_valid_reg[ridx_reg[PIDX_W-1:0]];
    assign p_match = p_in && p_vb && (port_rd_reg == cur_reg.port);
    assign app_hit = |(app_mask_reg & cur_reg.app_sel);

    assign res_push = (state_reg == S_OUT);
    assign res_item = res_reg;

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        idx_next        = idx_reg;
        rv_next         = 1'b0;
        a_found_next    = a_found_reg;
        a_hit_next      = a_hit_reg;
        a_free_next     = a_free_reg;
        a_fidx_next     = a_fidx_reg;
        p_found_next    = p_found_reg;
        p_hit_next      = p_hit_reg;
        p_free_next     = p_free_reg;
        p_fidx_next     = p_fidx_reg;
        addr_valid_next = addr_valid_reg;
        port_valid_next = port_valid_reg;
        app_mask_next   = app_mask_reg;
        ip_cnt_next     = ip_cnt_reg;
        app_cnt_next    = app_cnt_reg;
        port_cnt_next   = port_cnt_reg;
        res_next        = res_reg;
        q_take          = 1'b0;
        a_we            = 1'b0;
        p_we            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_take       = 1'b1;
                    cur_next     = q_item;
                    idx_next     = '0;
                    a_found_next = 1'b0;
                    a_free_next  = 1'b0;
                    p_found_next = 1'b0;
                    p_free_next  = 1'b0;
                    state_next   = q_item.scan ? S_SCAN : S_EVAL;
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                    rv_next  = 1'b1;
                end
                if (rv_reg)
                begin
                    if (a_match && !a_found_reg)
                    begin
                        a_found_next = 1'b1;
                        a_hit_next   = ridx_reg[AIDX_W-1:0];
                    end
                    if (a_in && !a_vb && !a_free_reg)
                    begin
                        a_free_next = 1'b1;
                        a_fidx_next = ridx_reg[AIDX_W-1:0];
                    end
                    if (p_match && !p_found_reg)
                    begin
                        p_found_next = 1'b1;
                        p_hit_next   = ridx_reg[PIDX_W-1:0];
                    end
                    if (p_in && !p_vb && !p_free_reg)
                    begin
                        p_free_next = 1'b1;
                        p_fidx_next = ridx_reg[PIDX_W-1:0];
                    end
                end
                if (!issue && !rv_reg)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                res_next.blocked = 1'b0;
                res_next.reason  = RSN_NONE;
                res_next.status  = ST_DONE;
                unique case (cur_reg.cmd)
                    CMD_CHECK:
                    begin
                        priority if (a_found_reg)
                            res_next.reason = RSN_ADDR;
                        else if (app_hit)
                            res_next.reason = RSN_APP;
                        else if (p_found_reg)
                            res_next.reason = RSN_PORT;
                        else
                            res_next.reason = RSN_NONE;
                        res_next.blocked = a_found_reg || app_hit || p_found_reg;
                    end
                    CMD_BLOCK_IP:
                    begin
                        if (!a_found_reg)
                        begin
                            if (a_free_reg)
                            begin
                                a_we                        = 1'b1;
                                addr_valid_next[a_fidx_reg] = 1'b1;
                                ip_cnt_next                 = ip_cnt_reg + 1'b1;
                            end
                            else
                            begin
                                res_next.status = ST_FULL;
                            end
                        end
                    end
                    CMD_UNBLOCK_IP:
                    begin
                        if (a_found_reg)
                        begin
                            addr_valid_next[a_hit_reg] = 1'b0;
                            ip_cnt_next                = ip_cnt_reg - 1'b1;
                        end
                    end
                    CMD_BLOCK_APP:
                    begin
                        app_mask_next = app_mask_reg | cur_reg.app_sel;
                        if (|(cur_reg.app_sel & ~app_mask_reg))
                        begin
                            app_cnt_next = app_cnt_reg + 1'b1;
                        end
                    end
                    CMD_UNBLOCK_APP:
                    begin
                        app_mask_next = app_mask_reg & ~cur_reg.app_sel;
                        if (app_hit)
                        begin
                            app_cnt_next = app_cnt_reg - 1'b1;
                        end
                    end
                    CMD_BLOCK_PORT:
                    begin
                        if (!p_found_reg)
                        begin
                            if (p_free_reg)
                            begin
                                p_we                        = 1'b1;
                                port_valid_next[p_fidx_reg] = 1'b1;
                                port_cnt_next               = port_cnt_reg + 1'b1;
                            end
                            else
                            begin
                                res_next.status = ST_FULL;
                            end
                        end
                    end
                    CMD_UNBLOCK_PORT:
                    begin
                        if (p_found_reg)
                        begin
                            port_valid_next[p_hit_reg] = 1'b0;
                            port_cnt_next              = port_cnt_reg - 1'b1;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        addr_valid_next = '0;
                        port_valid_next = '0;
                        app_mask_next   = '0;
                        ip_cnt_next     = '0;
                        app_cnt_next    = '0;
                        port_cnt_next   = '0;
                    end
                endcase
                res_next.ip_rules   = ip_cnt_next;
                res_next.app_rules  = app_cnt_next;
                res_next.port_rules = port_cnt_next;
                state_next          = S_OUT;
            end
            S_OUT:
            begin
                if (!res_full)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rv_reg         <= 1'b0;
            addr_valid_reg <= '0;
            port_valid_reg <= '0;
            app_mask_reg   <= '0;
            ip_cnt_reg     <= '0;
            app_cnt_reg    <= '0;
            port_cnt_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rv_reg         <= rv_next;
            addr_valid_reg <= addr_valid_next;
            port_valid_reg <= port_valid_next;
            app_mask_reg   <= app_mask_next;
            ip_cnt_reg     <= ip_cnt_next;
            app_cnt_reg    <= app_cnt_next;
            port_cnt_reg   <= port_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        idx_reg     <= idx_next;
        ridx_reg    <= idx_reg;
        a_found_reg <= a_found_next;
        a_hit_reg   <= a_hit_next;
        a_free_reg  <= a_free_next;
        a_fidx_reg  <= a_fidx_next;
        p_found_reg <= p_found_next;
        p_hit_reg   <= p_hit_next;
        p_free_reg  <= p_free_next;
        p_fidx_reg  <= p_fidx_next;
        res_reg     <= res_next;
    end

    // address table memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            addr_mem[a_fidx_reg] <= cur_reg.ip;
        end
        addr_rd_reg <= addr_mem[idx_reg[AIDX_W-1:0]];
    end

    // port table memory
    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            port_mem[p_fidx_reg] <= cur_reg.port;
        end
        port_rd_reg <= port_mem[idx_reg[PIDX_W-1:0]];
    end

endmodule

/* rtl/pbl_resq.sv */
// result queue: holds finished result beats until the consumer pops them
module pbl_resq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            res_push,
    input  pbl_pkg::res_t                   res_item,
    output logic                            res_full,
    output logic                            empty,
    input  logic                            pop,
    output logic                            blocked,
    output logic [pbl_pkg::REASON_W-1:0]    reason,
    output logic                            status,
    output logic [pbl_pkg::IPCNT_W-1:0]     ip_rules,
    output logic [pbl_pkg::APPCNT_W-1:0]    app_rules,
    output logic [pbl_pkg::PORTCNT_W-1:0]   port_rules
);
    import pbl_pkg::*;

    res_t               mem_q [Q_DEPTH];
    res_t               head;
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    assign res_full = (cnt_reg == QCNT_W'(Q_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    assign head       = mem_q[rd_ptr_reg];
    assign blocked    = head.blocked;
    assign reason     = head.reason;
    assign status     = head.status;
    assign ip_rules   = head.ip_rules;
    assign app_rules  = head.app_rules;
    assign port_rules = head.port_rules;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_q[wr_ptr_reg] <= res_item;
        end
    end

endmodule

/* rtl/packet_block_list_filter_unit.sv */
// top level of the packet block-list filter
// Queue-style ports on both sides: push/full in, empty/pop out, one result beat per
// input beat, in order. Checks and address or port adds/removes scan the address and
// port tables together, one entry per cycle through each table's single read port;
// application adds/removes and clear-all skip the scan. Two-entry queues in front of
// and behind the execution engine let the input side and the result side stall
// independently. Rule counts in every result are taken after the command; the tables
// need no clearing pass after reset, since per-entry valid bits gate every read.
module packet_block_list_filter_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [pbl_pkg::CMD_W-1:0]       cmd,
    input  logic [pbl_pkg::IP_W-1:0]        ip_addr,
    input  logic [pbl_pkg::PORT_W-1:0]      port_num,
    input  logic [pbl_pkg::APP_W-1:0]       app_id,
    output logic                            empty,
    input  logic                            pop,
    output logic                            blocked,
    output logic [pbl_pkg::REASON_W-1:0]    reason,
    output logic                            status,
    output logic [pbl_pkg::IPCNT_W-1:0]     ip_rules,
    output logic [pbl_pkg::APPCNT_W-1:0]    app_rules,
    output logic [pbl_pkg::PORTCNT_W-1:0]   port_rules
);
    import pbl_pkg::*;

    logic   q_valid;
    item_t  q_item;
    logic   q_take;
    logic   res_push;
    res_t   res_item;
    logic   res_full;

    pbl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .cmd      (cmd),
        .ip_addr  (ip_addr),
        .port_num (port_num),
        .app_id   (app_id),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_take   (q_take)
    );

    pbl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_take   (q_take),
        .res_push (res_push),
        .res_item (res_item),
        .res_full (res_full)
    );

    pbl_resq u_resq (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_push   (res_push),
        .res_item   (res_item),
        .res_full   (res_full),
        .empty      (empty),
        .pop        (pop),
        .blocked    (blocked),
        .reason     (reason),
        .status     (status),
        .ip_rules   (ip_rules),
        .app_rules  (app_rules),
        .port_rules (port_rules)
    );

endmodule

/* rtl/pbl_checker.sv */
// port-level checker for the filter, bound to the top level
module pbl_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            empty,
    input  logic                            pop,
    input  logic                            blocked,
    input  logic [pbl_pkg::REASON_W-1:0]    reason,
    input  logic                            status,
    input  logic [pbl_pkg::IPCNT_W-1:0]     ip_rules,
    input  logic [pbl_pkg::APPCNT_W-1:0]    app_rules,
    input  logic [pbl_pkg::PORTCNT_W-1:0]   port_rules
);
    import pbl_pkg::*;

    // a result is blocked exactly when it names a reason
    a_blocked_reason: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (blocked == (reason != RSN_NONE)))
        else $error("blocked flag disagrees with reason");

    // a dropped insert is never a check result
    a_full_not_check: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == ST_FULL)) |-> !blocked)
        else $error("full status on a blocked check");

    // a waiting result beat holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable({blocked, reason, status,
                                                 ip_rules, app_rules, port_rules})))
        else $error("result beat changed while stalled");

    a_ip_count: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((ADDR_ENTRIES > 127) || (int'(ip_rules) <= ADDR_ENTRIES)))
        else $error("address rule count above table size");

    a_app_count: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((APP_TYPES > 63) || (int'(app_rules) <= APP_TYPES)))
        else $error("application rule count above type count");

endmodule

bind packet_block_list_filter_unit pbl_checker u_pbl_checker (.*);

/* dv/pbl_filter_checker.sv */
// checker for the packet block-list filter: predicts each result beat and compares it
module pbl_filter_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          full,
    input  logic [pbl_pkg::CMD_W-1:0]     cmd,
    input  logic [pbl_pkg::IP_W-1:0]      ip_addr,
    input  logic [pbl_pkg::PORT_W-1:0]    port_num,
    input  logic [pbl_pkg::APP_W-1:0]     app_id,
    input  logic                          empty,
    input  logic                          pop,
    input  logic                          blocked,
    input  logic [pbl_pkg::REASON_W-1:0]  reason,
    input  logic                          status,
    input  logic [pbl_pkg::IPCNT_W-1:0]   ip_rules,
    input  logic [pbl_pkg::APPCNT_W-1:0]  app_rules,
    input  logic [pbl_pkg::PORTCNT_W-1:0] port_rules,
    output int                            mismatches,
    output int                            pending
);
    import pbl_pkg::*;

    logic [IP_W-1:0]      addr_tab [ADDR_ENTRIES];
    logic                 addr_vld [ADDR_ENTRIES];
    logic [APP_TYPES-1:0] app_msk;
    logic [PORT_W-1:0]    port_tab [PORT_ENTRIES];
    logic                 port_vld [PORT_ENTRIES];

    res_t verdicts_due[$];

    function automatic int find_addr(input logic [IP_W-1:0] a);
        for (int i = 0; i < ADDR_ENTRIES; i++)
            if (addr_vld[i] && addr_tab[i] == a)
                return i;
        return -1;
    endfunction

    function automatic int find_port(input logic [PORT_W-1:0] p);
        for (int i = 0; i < PORT_ENTRIES; i++)
            if (port_vld[i] && port_tab[i] == p)
                return i;
        return -1;
    endfunction

    // updates the rule lists for one command and returns the verdict it produces
    task automatic apply_rule_cmd(input logic [CMD_W-1:0] c, input logic [IP_W-1:0] ip,
                                  input logic [PORT_W-1:0] p, input logic [APP_W-1:0] a,
                                  output res_t r);
        int k;
        int nip;
        int napp;
        int nport;
        r = '0;
        k = -1;
        case (c)
            CMD_CHECK:
            begin
                if (find_addr(ip) >= 0)
                    r.reason = RSN_ADDR;
                else if (a < APP_TYPES && app_msk[a])
                    r.reason = RSN_APP;
                else if (find_port(p) >= 0)
                    r.reason = RSN_PORT;
                r.blocked = (r.reason != RSN_NONE);
            end
            CMD_BLOCK_IP:
            begin
                if (find_addr(ip) < 0)
                begin
                    // lowest free slot takes the new entry
                    for (int i = 0; i < ADDR_ENTRIES; i++)
                        if (!addr_vld[i] && k < 0)
                            k = i;
                    if (k < 0)
                        r.status = ST_FULL;
                    else
                    begin
                        addr_tab[k] = ip;
                        addr_vld[k] = 1'b1;
                    end
                end
            end
            CMD_UNBLOCK_IP:
            begin
                k = find_addr(ip);
                if (k >= 0)
                    addr_vld[k] = 1'b0;
            end
            CMD_BLOCK_APP:
            begin
                if (a < APP_TYPES)
                    app_msk[a] = 1'b1;
            end
            CMD_UNBLOCK_APP:
            begin
                if (a < APP_TYPES)
                    app_msk[a] = 1'b0;
            end
            CMD_BLOCK_PORT:
            begin
                if (find_port(p) < 0)
                begin
                    for (int i = 0; i < PORT_ENTRIES; i++)
                        if (!port_vld[i] && k < 0)
                            k = i;
                    if (k < 0)
                        r.status = ST_FULL;
                    else
                    begin
                        port_tab[k] = p;
                        port_vld[k] = 1'b1;
                    end
                end
            end
            CMD_UNBLOCK_PORT:
            begin
                k = find_port(p);
                if (k >= 0)
                    port_vld[k] = 1'b0;
            end
            default:
            begin
                foreach (addr_vld[i])
                    addr_vld[i] = 1'b0;
                foreach (port_vld[i])
                    port_vld[i] = 1'b0;
                app_msk = '0;
            end
        endcase
        // counts are taken after the command
        nip = 0;
        napp = 0;
        nport = 0;
        foreach (addr_vld[i])
            nip += addr_vld[i];
        for (int i = 0; i < APP_TYPES; i++)
            napp += app_msk[i];
        foreach (port_vld[i])
            nport += port_vld[i];
        r.ip_rules   = IPCNT_W'(nip);
        r.app_rules  = APPCNT_W'(napp);
        r.port_rules = PORTCNT_W'(nport);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t due;
        res_t fresh;
        logic bad;
        if (!rst_n)
        begin
            foreach (addr_vld[i])
                addr_vld[i] = 1'b0;
            foreach (port_vld[i])
                port_vld[i] = 1'b0;
            app_msk = '0;
            verdicts_due.delete();
            mismatches = 0;
            pending <= 0;
        end
        else
        begin
            // result side first: a beat pushed at this edge cannot come out at the same edge
            if (pop && !empty)
            begin
                if (verdicts_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result beat blocked=%0d reason=%0d status=%0d",
                             $time, blocked, reason, status);
                end
                else
                begin
                    due = verdicts_due.pop_front();
                    bad = (blocked !== due.blocked) || (reason !== due.reason) ||
                          (status !== due.status) || (ip_rules !== due.ip_rules) ||
                          (app_rules !== due.app_rules) || (port_rules !== due.port_rules);
                    if (bad)
                    begin
                        mismatches++;
                        $display({"%0t: result mismatch expected blk=%0d rsn=%0d st=%0d ",
                                  "ip=%0d app=%0d port=%0d actual blk=%0d rsn=%0d st=%0d ",
                                  "ip=%0d app=%0d port=%0d"}, $time,
                                 due.blocked, due.reason, due.status, due.ip_rules,
                                 due.app_rules, due.port_rules, blocked, reason, status,
                                 ip_rules, app_rules, port_rules);
                    end
                end
            end
            if (push && !full)
            begin
                apply_rule_cmd(cmd, ip_addr, port_num, app_id, fresh);
                verdicts_due = {verdicts_due, fresh};
            end
            pending <= verdicts_due.size();
        end
    end

endmodule

/* dv/tb_packet_block_list_filter_unit.sv */
// testbench top for the packet block-list filter: stimulus, receiver stalls and verdict
module tb_packet_block_list_filter_unit;
    import pbl_pkg::*;

    localparam int ITEMS      = 950;
    localparam int IDLE_LIMIT = 3000;
    localparam int TAIL_CYCLES = 120;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 pop = 1'b0;
    logic [CMD_W-1:0]     cmd = CMD_CHECK;
    logic [IP_W-1:0]      ip_addr = '0;
    logic [PORT_W-1:0]    port_num = '0;
    logic [APP_W-1:0]     app_id = '0;
    logic                 full;
    logic                 empty;
    logic                 blocked;
    logic [REASON_W-1:0]  reason;
    logic                 status;
    logic [IPCNT_W-1:0]   ip_rules;
    logic [APPCNT_W-1:0]  app_rules;
    logic [PORTCNT_W-1:0] port_rules;

    int          mismatches;
    int          pending;
    int          sent = 0;
    int          burst_left = 0;
    int          quiet_cycles = 0;
    int unsigned cyc = 0;
    int          pop_mode = 0;

    logic [IP_W-1:0]   ip_pool [16];
    logic [PORT_W-1:0] port_pool [12];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    packet_block_list_filter_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .ip_addr    (ip_addr),
        .port_num   (port_num),
        .app_id     (app_id),
        .empty      (empty),
        .pop        (pop),
        .blocked    (blocked),
        .reason     (reason),
        .status     (status),
        .ip_rules   (ip_rules),
        .app_rules  (app_rules),
        .port_rules (port_rules)
    );

    pbl_filter_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .ip_addr    (ip_addr),
        .port_num   (port_num),
        .app_id     (app_id),
        .empty      (empty),
        .pop        (pop),
        .blocked    (blocked),
        .reason     (reason),
        .status     (status),
        .ip_rules   (ip_rules),
        .app_rules  (app_rules),
        .port_rules (port_rules),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // receiver: stall pattern switches among four randomly drawn modes
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc % 128 == 0)
            pop_mode <= $urandom_range(0, 3);
        case (pop_mode)
            0:       pop <= 1'b1;
            1:       pop <= ($urandom_range(0, 3) != 0);
            2:       pop <= ($urandom_range(0, 3) == 0);
            default: pop <= cyc[3];
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles <= 0;
            else if (quiet_cycles == IDLE_LIMIT)
            begin
                $display("FAIL packet_block_list_filter_unit");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send(input logic [CMD_W-1:0] c, input logic [IP_W-1:0] ip,
                        input logic [PORT_W-1:0] p, input logic [APP_W-1:0] a);
        int gap;
        push     <= 1'b1;
        cmd      <= c;
        ip_addr  <= ip;
        port_num <= p;
        app_id   <= a;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(0, 12);
        end
    endtask

    // hold off the input until every result beat has been taken
    task automatic drain_results();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [IP_W-1:0] pick_ip();
        return ($urandom_range(0, 3) != 0) ? ip_pool[$urandom_range(0, 15)] : $urandom();
    endfunction

    function automatic logic [PORT_W-1:0] pick_port();
        return ($urandom_range(0, 3) != 0) ? port_pool[$urandom_range(0, 11)]
                                           : PORT_W'($urandom());
    endfunction

    function automatic logic [APP_W-1:0] pick_app();
        return APP_W'($urandom());
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return CMD_CHECK;
        if (r < 62) return CMD_BLOCK_IP;
        if (r < 70) return CMD_UNBLOCK_IP;
        if (r < 76) return CMD_BLOCK_APP;
        if (r < 80) return CMD_UNBLOCK_APP;
        if (r < 90) return CMD_BLOCK_PORT;
        if (r < 97) return CMD_UNBLOCK_PORT;
        return CMD_CLEAR;
    endfunction

    initial
    begin
        int n;
        int kind;
        int start;
        logic [IP_W-1:0]   fill_ips [$];
        logic [PORT_W-1:0] fill_ports [$];

        foreach (ip_pool[i])
            ip_pool[i] = $urandom();
        foreach (port_pool[i])
            port_pool[i] = PORT_W'($urandom());
        ip_pool[0]   = '0;
        ip_pool[1]   = '1;
        port_pool[0] = '0;
        port_pool[1] = '1;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty lists, removals of absent entries
        send(CMD_CHECK, '0, '0, '0);
        send(CMD_UNBLOCK_IP, '1, '1, '1);
        send(CMD_UNBLOCK_APP, '1, '1, '1);
        send(CMD_UNBLOCK_PORT, '1, '1, '1);
        // inserts at the extremes, repeated inserts change nothing
        send(CMD_BLOCK_IP, '0, '1, '1);
        send(CMD_BLOCK_IP, '1, '0, '0);
        send(CMD_BLOCK_IP, '0, '0, '0);
        send(CMD_BLOCK_APP, '1, '1, '0);
        send(CMD_BLOCK_APP, '0, '0, '1);
        send(CMD_BLOCK_APP, '0, '0, '1);
        send(CMD_BLOCK_PORT, '1, '0, '1);
        send(CMD_BLOCK_PORT, '0, '1, '0);
        send(CMD_BLOCK_PORT, '0, '1, '0);
        // reason priority: address, then application, then port
        send(CMD_CHECK, '0, '0, '0);
        send(CMD_CHECK, 32'd1, '0, '0);
        send(CMD_CHECK, 32'd1, '1, 5'd1);
        send(CMD_CHECK, 32'd1, 16'd1, 5'd1);
        send(CMD_CHECK, '1, '1, '1);
        send(CMD_UNBLOCK_IP, '0, '0, '0);
        send(CMD_CHECK, '0, '0, '0);
        send(CMD_UNBLOCK_APP, '0, '0, '0);
        send(CMD_UNBLOCK_PORT, '0, '0, '0);
        send(CMD_CHECK, '0, '0, '0);
        send(CMD_CLEAR, '1, '1, '1);
        send(CMD_CHECK, '1, '1, '1);
        drain_results();

        start = sent;
        while (sent - start < ITEMS)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 10)
            begin
                n = $urandom_range(10, 40);
                repeat (n) send(pick_cmd(), pick_ip(), pick_port(), pick_app());
            end
            else if (kind < 13)
            begin
                // fill the address table near or past its capacity, then hit and remove entries
                if ($urandom_range(0, 1) != 0)
                    send(CMD_CLEAR, $urandom(), pick_port(), pick_app());
                fill_ips.delete();
                n = $urandom_range(60, 72);
                repeat (n)
                begin
                    fill_ips = {fill_ips,
                                (($urandom_range(0, 7) == 0) ? pick_ip() : $urandom())};
                    send(CMD_BLOCK_IP, fill_ips[$], pick_port(), pick_app());
                end
                repeat (6)
                    send(CMD_CHECK, fill_ips[$urandom_range(0, n - 1)], pick_port(),
                         pick_app());
                repeat (4)
                    send(CMD_UNBLOCK_IP, fill_ips[$urandom_range(0, n - 1)], pick_port(),
                         pick_app());
                repeat (5)
                    send(CMD_BLOCK_IP, pick_ip(), pick_port(), pick_app());
                repeat (4)
                    send(CMD_CHECK, pick_ip(), pick_port(), pick_app());
            end
            else if (kind < 16)
            begin
                if ($urandom_range(0, 1) != 0)
                    send(CMD_CLEAR, $urandom(), pick_port(), pick_app());
                fill_ports.delete();
                n = $urandom_range(30, 40);
                repeat (n)
                begin
                    fill_ports = {fill_ports,
                                  (($urandom_range(0, 5) == 0) ? pick_port()
                                                               : PORT_W'($urandom()))};
                    send(CMD_BLOCK_PORT, $urandom(), fill_ports[$], pick_app());
                end
                repeat (6)
                    send(CMD_CHECK, $urandom(), fill_ports[$urandom_range(0, n - 1)],
                         pick_app());
                repeat (4)
                    send(CMD_UNBLOCK_PORT, $urandom(), fill_ports[$urandom_range(0, n - 1)],
                         pick_app());
                repeat (4)
                    send(CMD_BLOCK_PORT, $urandom(), pick_port(), pick_app());
            end
            else if (kind < 18)
            begin
                n = $urandom_range(10, 30);
                repeat (n)
                begin
                    case ($urandom_range(0, 2))
                        0:       send(CMD_BLOCK_APP, pick_ip(), pick_port(), pick_app());
                        1:       send(CMD_UNBLOCK_APP, pick_ip(), pick_port(), pick_app());
                        default: send(CMD_CHECK, pick_ip(), pick_port(), pick_app());
                    endcase
                end
            end
            else
            begin
                n = $urandom_range(5, 15);
                repeat (n) send(CMD_W'($urandom_range(0, 7)), $urandom(), PORT_W'($urandom()),
                                pick_app());
            end
            if ($urandom_range(0, 15) == 0)
                drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS packet_block_list_filter_unit");
        else
            $display("FAIL packet_block_list_filter_unit");
        $finish;
    end

endmodule
